// ===== src/alps_pkg.sv =====
// ----------------------------------------------------------------------------
// alps_pkg: shared types and constants for the activity LED pulse shaper
// Colour codes, register indexes, configuration bundle and channel result.
// ----------------------------------------------------------------------------
package alps_pkg;

   localparam int ALPS_TIME_BITS = 10;   // default width of the time counters
   localparam int CFG_W          = 10;   // width of the millisecond registers
   localparam int ELAPSED_W      = 10;   // width of elapsed_ms
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CFG_W-1:0] ON_TIME_RESET      = CFG_W'(80);
   localparam logic [CFG_W-1:0] GAP_TIME_RESET     = CFG_W'(20);
   localparam logic [CFG_W-1:0] FRESH_WINDOW_RESET = CFG_W'(20);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UPLINK_VIEW  = 2'd0,
      CSR_ON_TIME      = 2'd1,
      CSR_GAP_TIME     = 2'd2,
      CSR_FRESH_WINDOW = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      COL_OFF   = 2'd0,
      COL_GREEN = 2'd1,
      COL_AMBER = 2'd2
   } colour_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_GAP  = 3'b010,
      PH_ON   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] on_time;
      logic [CFG_W-1:0] gap_time;
      logic [CFG_W-1:0] fresh_window;
   } chan_cfg_type;

   typedef struct packed {
      colour_type colour;
      logic       started;
   } chan_out_type;

endpackage

// ===== src/alps_channel.sv =====
// ----------------------------------------------------------------------------
// alps_channel: one LED channel
// Gap / on-pulse sequencer with coalesced pending flags and activity ages.
// ----------------------------------------------------------------------------
module alps_channel import alps_pkg::*; #(
   parameter int TIME_BITS = ALPS_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 linked,
   input  logic                 rx,
   input  logic                 tx,
   input  logic [ELAPSED_W-1:0] elapsed,
   input  chan_cfg_type         cfg,
   output chan_out_type         result
);

   localparam int SUM_W = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   phase_type            phase_ff, phase_in;
   colour_type           colour_ff, colour_in;
   logic                 alt_ff, alt_in;
   logic                 pend_rx_ff, pend_rx_in;
   logic                 pend_tx_ff, pend_tx_in;
   logic                 rx_ever_ff, rx_ever_in;
   logic                 tx_ever_ff, tx_ever_in;
   logic [TIME_BITS-1:0] remain_ff, remain_in;
   logic [TIME_BITS-1:0] rx_age_ff, rx_age_in;
   logic [TIME_BITS-1:0] tx_age_ff, tx_age_in;

   logic [SUM_W-1:0]     elapsed_ext;
   logic [SUM_W-1:0]     rx_sum, tx_sum;
   logic [TIME_BITS-1:0] gap_load, on_load;
   logic                 rx_fresh, tx_fresh;
   logic                 done;
   chan_out_type         res;

   function automatic logic [TIME_BITS-1:0] clamp_time(input logic [SUM_W-1:0] v);
      logic [TIME_BITS-1:0] r;
      r = (v > SUM_W'(TIME_MAX)) ? TIME_MAX : v[TIME_BITS-1:0];
      return r;
   endfunction

   assign elapsed_ext = SUM_W'(elapsed);
   assign gap_load    = clamp_time(SUM_W'(cfg.gap_time));
   assign on_load     = clamp_time(SUM_W'(cfg.on_time));

   always_comb begin
      // advance time first
      remain_in = (SUM_W'(remain_ff) > elapsed_ext) ?
                  TIME_BITS'(SUM_W'(remain_ff) - elapsed_ext) : '0;
      rx_sum    = SUM_W'(rx_age_ff) + elapsed_ext;
      tx_sum    = SUM_W'(tx_age_ff) + elapsed_ext;
      rx_age_in = clamp_time(rx_sum);
      tx_age_in = clamp_time(tx_sum);

      phase_in   = phase_ff;
      colour_in  = colour_ff;
      alt_in     = alt_ff;
      pend_rx_in = pend_rx_ff;
      pend_tx_in = pend_tx_ff;
      rx_ever_in = rx_ever_ff;
      tx_ever_in = tx_ever_ff;
      res.colour  = COL_OFF;
      res.started = 1'b0;
      done        = 1'b0;
      rx_fresh    = 1'b0;
      tx_fresh    = 1'b0;

      if (!linked) begin
         // drop the channel back to its reset state
         phase_in   = PH_IDLE;
         colour_in  = COL_OFF;
         alt_in     = 1'b0;
         pend_rx_in = 1'b0;
         pend_tx_in = 1'b0;
         rx_ever_in = 1'b0;
         tx_ever_in = 1'b0;
         remain_in  = '0;
         rx_age_in  = '0;
         tx_age_in  = '0;
      end else begin
         if (rx) begin
            pend_rx_in = 1'b1;
            rx_age_in  = '0;
            rx_ever_in = 1'b1;
         end
         if (tx) begin
            pend_tx_in = 1'b1;
            tx_age_in  = '0;
            tx_ever_in = 1'b1;
         end
         if (phase_ff == PH_IDLE) begin
            if (!rx && !tx) begin
               res.colour = COL_GREEN;
               done       = 1'b1;
            end else begin
               phase_in  = PH_GAP;
               remain_in = gap_load;
            end
         end
         if (!done && phase_in == PH_GAP) begin
            done = 1'b1;
            if (remain_in != '0) begin
               res.colour = COL_OFF;
            end else begin
               phase_in  = PH_ON;
               remain_in = on_load;
               if (pend_rx_in && pend_tx_in) begin
                  alt_in    = !alt_ff;
                  colour_in = alt_in ? COL_AMBER : COL_GREEN;
               end else begin
                  colour_in = pend_tx_in ? COL_AMBER : COL_GREEN;
               end
               pend_rx_in  = 1'b0;
               pend_tx_in  = 1'b0;
               res.started = 1'b1;
               res.colour  = colour_in;
            end
         end
         if (!done) begin
            if (remain_in != '0) begin
               res.colour = colour_ff;
            end else begin
               // pulse over: start another cycle only on fresh activity
               rx_fresh   = SUM_W'(rx_age_in) < SUM_W'(cfg.fresh_window);
               tx_fresh   = SUM_W'(tx_age_in) < SUM_W'(cfg.fresh_window);
               pend_rx_in = rx_ever_in && rx_fresh;
               pend_tx_in = tx_ever_in && tx_fresh;
               if (pend_rx_in || pend_tx_in) begin
                  phase_in   = PH_GAP;
                  remain_in  = gap_load;
                  res.colour = COL_OFF;
               end else begin
                  phase_in   = PH_IDLE;
                  res.colour = COL_GREEN;
               end
            end
         end
      end
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         colour_ff  <= COL_OFF;
         alt_ff     <= 1'b0;
         pend_rx_ff <= 1'b0;
         pend_tx_ff <= 1'b0;
         rx_ever_ff <= 1'b0;
         tx_ever_ff <= 1'b0;
         remain_ff  <= '0;
         rx_age_ff  <= '0;
         tx_age_ff  <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         colour_ff  <= colour_in;
         alt_ff     <= alt_in;
         pend_rx_ff <= pend_rx_in;
         pend_tx_ff <= pend_tx_in;
         rx_ever_ff <= rx_ever_in;
         tx_ever_ff <= tx_ever_in;
         remain_ff  <= remain_in;
         rx_age_ff  <= rx_age_in;
         tx_age_ff  <= tx_age_in;
      end
   end

endmodule

// ===== src/activity_led_pulse_shaper.sv =====
// ----------------------------------------------------------------------------
// activity_led_pulse_shaper: WAN / LAN activity LED pulse shaper
// Turns per-window link and activity flags into LED colours and pulse marks.
// ----------------------------------------------------------------------------
// One beat on the req_ channel is one sample window; exactly one rsp_ beat
// comes back for each, in order. The block takes one window per clock cycle
// while req_stall is low. The window is first caught in an input register,
// then both channel sequencers update their state in a single pass and the
// LED colours land in the result register, which drives rsp_valid. While a
// result waits under rsp_stall, one more window can still enter the input
// register; req_stall rises only once both registers are full. Write the csr_
// registers only while no window is in flight (index 0 uplink view, 1 on time,
// 2 gap time, 3 freshness window, the last three in milliseconds). Time
// counters are TIME_BITS wide and saturate.
// ----------------------------------------------------------------------------
module activity_led_pulse_shaper import alps_pkg::*; #(
   parameter int TIME_BITS = ALPS_TIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   // window in
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_wan_linked,
   input  logic                   req_wan_rx_seen,
   input  logic                   req_wan_tx_seen,
   input  logic                   req_lan_linked,
   input  logic                   req_lan_seen,
   input  logic                   req_uplink_online,
   input  logic [ELAPSED_W-1:0]   req_elapsed_ms,
   // result out
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_wan_green,
   output logic                   rsp_wan_amber,
   output logic                   rsp_lan_led,
   output logic                   rsp_wan_pulse_started,
   output logic                   rsp_lan_pulse_started
);

   // configuration registers
   logic             uplink_view_ff;
   chan_cfg_type     cfg_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 wan_linked_ff, wan_rx_ff, wan_tx_ff;
   logic                 lan_linked_ff, lan_seen_ff, online_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic                 wan_green_ff, wan_amber_ff, lan_led_ff;
   logic                 wan_started_ff, lan_started_ff;

   logic                 req_take;
   logic                 advance;
   logic                 wan_offline;
   logic                 wan_keep;
   chan_out_type         wan_res, lan_res;
   colour_type           wan_colour;
   logic                 wan_started;

   // register writes; unknown indexes cannot occur with a two-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         uplink_view_ff      <= 1'b0;
         cfg_ff.on_time      <= ON_TIME_RESET;
         cfg_ff.gap_time     <= GAP_TIME_RESET;
         cfg_ff.fresh_window <= FRESH_WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_UPLINK_VIEW:  uplink_view_ff      <= csr_wdata[0];
            CSR_ON_TIME:      cfg_ff.on_time      <= csr_wdata;
            CSR_GAP_TIME:     cfg_ff.gap_time     <= csr_wdata;
            CSR_FRESH_WINDOW: cfg_ff.fresh_window <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the held window into the result register whenever the result
   // slot is empty or being drained this cycle.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture the window payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         wan_linked_ff <= req_wan_linked;
         wan_rx_ff     <= req_wan_rx_seen;
         wan_tx_ff     <= req_wan_tx_seen;
         lan_linked_ff <= req_lan_linked;
         lan_seen_ff   <= req_lan_seen;
         online_ff     <= req_uplink_online;
         elapsed_ff    <= req_elapsed_ms;
      end
   end

   // Green mode with the uplink offline clears the WAN channel exactly as a
   // dropped link would, so fold it into the channel's link input.
   assign wan_offline = uplink_view_ff && wan_linked_ff && !online_ff;
   assign wan_keep    = wan_linked_ff && !wan_offline;

   alps_channel #(
      .TIME_BITS (TIME_BITS)
   ) u_wan_channel (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .linked  (wan_keep),
      .rx      (wan_rx_ff),
      .tx      (wan_tx_ff),
      .elapsed (elapsed_ff),
      .cfg     (cfg_ff),
      .result  (wan_res)
   );

   // LAN activity counts as receive only, so the LAN LED is never amber
   alps_channel #(
      .TIME_BITS (TIME_BITS)
   ) u_lan_channel (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .linked  (lan_linked_ff),
      .rx      (lan_seen_ff),
      .tx      (1'b0),
      .elapsed (elapsed_ff),
      .cfg     (cfg_ff),
      .result  (lan_res)
   );

   // Green mode: amber marks an offline uplink, traffic amber folds to green
   always_comb begin
      wan_colour  = wan_res.colour;
      wan_started = wan_res.started;
      if (uplink_view_ff) begin
         if (wan_offline) begin
            wan_colour  = COL_AMBER;
            wan_started = 1'b0;
         end else if (wan_res.colour == COL_AMBER) begin
            wan_colour = COL_GREEN;
         end
      end
   end

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (advance) begin
         wan_green_ff   <= (wan_colour == COL_GREEN);
         wan_amber_ff   <= (wan_colour == COL_AMBER);
         lan_led_ff     <= (lan_res.colour != COL_OFF);
         wan_started_ff <= wan_started;
         lan_started_ff <= lan_res.started;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_wan_green         = wan_green_ff;
   assign rsp_wan_amber         = wan_amber_ff;
   assign rsp_lan_led           = lan_led_ff;
   assign rsp_wan_pulse_started = wan_started_ff;
   assign rsp_lan_pulse_started = lan_started_ff;

endmodule
